// ===== src/ph_trimmed_mean_filter_defines.svh =====
// ----------------------------------------------------------------------------
// ph_trimmed_mean_filter_defines
// Assertion macros for the trimmed-mean pH filter.
// ----------------------------------------------------------------------------
`ifndef PH_TRIMMED_MEAN_FILTER_DEFINES_SVH
`define PH_TRIMMED_MEAN_FILTER_DEFINES_SVH

`ifndef SYNTH
`define PHTM_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PHTM_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PHTM_ASSERT_SAME(lbl, a, b)
`define PHTM_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// ===== src/phtm_pkg.sv =====
// ----------------------------------------------------------------------------
// phtm_pkg
// Shared types and constants of the trimmed-mean pH filter.
// ----------------------------------------------------------------------------
`default_nettype none

package phtm_pkg;

    localparam int BURST_W    = 6;
    localparam int SLOPE_W    = 13;
    localparam int MILLI_W    = 15;
    localparam int AVG_W      = 20;
    localparam int PROD_W     = SLOPE_W + AVG_W + 1;
    localparam int PH_W       = 20;
    localparam int Q_SHIFT    = 16;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [BURST_W-1:0] RST_BURST_LENGTH = 6'd20;
    localparam logic [SLOPE_W-1:0] RST_SLOPE_Q8     = 13'h1B96;
    localparam logic [MILLI_W-1:0] RST_INTERCEPT    = 15'd15132;
    localparam logic [MILLI_W-1:0] RST_FALLBACK     = 15'd6900;

    localparam logic [AVG_W-1:0]   AVG_MAX = 20'hFFFFF;
    localparam logic [MILLI_W-1:0] PH_MAX  = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_LENGTH = 2'd0,
        CFG_SLOPE_Q8     = 2'd1,
        CFG_INTERCEPT    = 2'd2,
        CFG_FALLBACK     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope_q8;
        logic [MILLI_W-1:0] intercept_milli;
        logic [MILLI_W-1:0] fallback_milli;
    } t_cal;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_LOAD,
        B_DIV,
        B_SAT,
        B_MUL,
        B_PUT
    } t_bstate;

endpackage

`default_nettype wire

// ===== src/phtm_front.sv =====
// ----------------------------------------------------------------------------
// phtm_front
// Sample intake: counts samples against the burst length and tags the
// sample that completes a burst.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire  [SAMPLE_BITS-1:0]            i_adc_sample,
    input  wire  [phtm_pkg::BURST_W-1:0]      i_burst_length,
    input  wire                               i_full,
    output logic                              o_stall,
    output logic                              o_push,
    output logic [SAMPLE_BITS:0]              o_item
);

    logic [phtm_pkg::BURST_W-1:0] r_bcnt;
    logic [phtm_pkg::BURST_W-1:0] n_bcnt;
    logic [phtm_pkg::BURST_W-1:0] w_next;
    logic                         w_emit;

    assign w_next  = r_bcnt + 1'b1;
    assign w_emit  = (w_next == i_burst_length);
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_item  = {w_emit, i_adc_sample};

    always_comb begin
        n_bcnt = r_bcnt;
        if (o_push) begin
            n_bcnt = w_emit ? '0 : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else begin
            r_bcnt <= n_bcnt;
        end
    end

endmodule

`default_nettype wire

// ===== src/phtm_queue.sv =====
// ----------------------------------------------------------------------------
// phtm_queue
// Two-entry queue between sample intake and the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_queue #(
    parameter int DATA_W = 13
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/phtm_back.sv =====
// ----------------------------------------------------------------------------
// phtm_back
// Window engine: stores samples in the ring, scans it for sum, minimum and
// maximum, divides by reciprocal multiplication, scales to milli-pH and holds
// the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module phtm_back #(
    parameter int WINDOW      = 40,
    parameter int SAMPLE_BITS = 12
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_empty,
    input  wire  [SAMPLE_BITS:0]                i_item,
    output logic                                o_pop,
    input  phtm_pkg::t_cal                      i_cal,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [phtm_pkg::MILLI_W-1:0]        o_ph_milli,
    output logic [phtm_pkg::AVG_W-1:0]          o_average_q8
);

    localparam int AW      = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DV_W    = SUM_W + phtm_pkg::FRAC_W;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int DIVISOR = WINDOW - 2;
    localparam int RCP_SH  = DV_W + $clog2(DIVISOR);
    localparam int RCP_W   = DV_W + 1;
    localparam int QP_W    = SUM_W + RCP_W;
    localparam int Q_SH    = RCP_SH - phtm_pkg::FRAC_W;
    localparam int QX_W    = (DV_W > phtm_pkg::AVG_W) ? DV_W : phtm_pkg::AVG_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    phtm_pkg::t_bstate r_state;
    phtm_pkg::t_bstate n_state;

    logic [SAMPLE_BITS-1:0]              r_mem [WINDOW];
    logic [WINDOW-1:0]                   r_vld;
    logic [AW-1:0]                       r_wpos;
    logic [CNT_W-1:0]                    r_cnt;
    logic [SAMPLE_BITS-1:0]              r_rdata;
    logic                                r_rvld;
    logic                                r_dv;
    logic [SUM_W-1:0]                    r_sum;
    logic [SAMPLE_BITS-1:0]              r_lo;
    logic [SAMPLE_BITS-1:0]              r_hi;
    logic [SUM_W-1:0]                    r_dvd;
    logic [QP_W-1:0]                     r_qprod;
    logic [phtm_pkg::AVG_W-1:0]          r_avg;
    logic signed [phtm_pkg::PROD_W-1:0]  r_prod;
    logic                                r_ovld;
    logic [phtm_pkg::MILLI_W-1:0]        r_ph;
    logic [phtm_pkg::AVG_W-1:0]          r_oavg;

    logic                                w_emit;
    logic                                w_rd;
    logic                                w_free;
    logic                                w_load_out;
    logic [SAMPLE_BITS-1:0]              w_val;
    logic [SUM_W-1:0]                    w_trim;
    logic [QX_W-1:0]                     w_qx;
    logic signed [phtm_pkg::PH_W-1:0]    w_ph;
    logic [phtm_pkg::MILLI_W-1:0]        w_ph_out;

    assign w_emit = i_item[SAMPLE_BITS];
    assign w_free = !r_ovld || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            phtm_pkg::B_IDLE: begin
                if (!i_empty && w_emit) begin
                    n_state = phtm_pkg::B_SCAN;
                end
            end
            phtm_pkg::B_SCAN: begin
                if (r_cnt == CNT_W'(WINDOW)) begin
                    n_state = phtm_pkg::B_LOAD;
                end
            end
            phtm_pkg::B_LOAD: n_state = phtm_pkg::B_DIV;
            phtm_pkg::B_DIV:  n_state = phtm_pkg::B_SAT;
            phtm_pkg::B_SAT:  n_state = phtm_pkg::B_MUL;
            phtm_pkg::B_MUL:  n_state = phtm_pkg::B_PUT;
            phtm_pkg::B_PUT: begin
                if (w_free) begin
                    n_state = phtm_pkg::B_IDLE;
                end
            end
            default: n_state = phtm_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_rd       = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            phtm_pkg::B_IDLE: o_pop      = !i_empty;
            phtm_pkg::B_SCAN: w_rd       = (r_cnt < CNT_W'(WINDOW));
            phtm_pkg::B_PUT:  w_load_out = w_free;
            default: begin
                o_pop      = 1'b0;
                w_rd       = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign w_val  = r_rvld ? r_rdata : '0;
    assign w_trim = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);
    assign w_qx   = QX_W'(r_qprod >> Q_SH);
    assign w_ph   = $signed({{(phtm_pkg::PH_W - phtm_pkg::MILLI_W){1'b0}},
                             i_cal.intercept_milli})
                  + phtm_pkg::PH_W'($signed(r_prod[phtm_pkg::PROD_W-1:phtm_pkg::Q_SHIFT]));

    always_comb begin
        if (w_ph > $signed(phtm_pkg::PH_W'(phtm_pkg::PH_MAX))) begin
            w_ph_out = phtm_pkg::PH_MAX;
        end else if (w_ph <= $signed(phtm_pkg::PH_W'(0))) begin
            w_ph_out = i_cal.fallback_milli;
        end else begin
            w_ph_out = w_ph[phtm_pkg::MILLI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phtm_pkg::B_IDLE;
            r_vld   <= '0;
            r_wpos  <= '0;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_rd;
            if (o_pop) begin
                r_vld[r_wpos] <= 1'b1;
                r_wpos <= (r_wpos == AW'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
            end
            if (r_state == phtm_pkg::B_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_load_out) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[r_wpos] <= i_item[SAMPLE_BITS-1:0];
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_cnt[AW-1:0]];
            r_rvld  <= r_vld[r_cnt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum <= '0;
            r_lo  <= '1;
            r_hi  <= '0;
        end else if (r_dv) begin
            r_sum <= r_sum + SUM_W'(w_val);
            if (w_val < r_lo) begin
                r_lo <= w_val;
            end
            if (w_val > r_hi) begin
                r_hi <= w_val;
            end
        end
        case (r_state)
            phtm_pkg::B_LOAD: begin
                r_dvd <= w_trim;
            end
            phtm_pkg::B_DIV: begin
                r_qprod <= QP_W'(r_dvd) * QP_W'(RECIP);
            end
            phtm_pkg::B_SAT: begin
                r_avg <= (w_qx > QX_W'(phtm_pkg::AVG_MAX)) ? phtm_pkg::AVG_MAX
                                                           : w_qx[phtm_pkg::AVG_W-1:0];
            end
            phtm_pkg::B_MUL: begin
                r_prod <= $signed(i_cal.slope_q8) * $signed({1'b0, r_avg});
            end
            default: begin
                r_avg <= r_avg;
            end
        endcase
        if (w_load_out) begin
            r_ph   <= w_ph_out;
            r_oavg <= r_avg;
        end
    end

    assign o_valid      = r_ovld;
    assign o_ph_milli   = r_ph;
    assign o_average_q8 = r_oavg;

endmodule

`default_nettype wire

// ===== src/ph_trimmed_mean_filter.sv =====
// ----------------------------------------------------------------------------
// ph_trimmed_mean_filter
// Trimmed-mean moving average of ADC samples, scaled to milli-pH.
// ----------------------------------------------------------------------------
// Input beats (i_valid / o_stall) carry one ADC sample each; a sample is
// taken when i_valid is high and o_stall low. Every burst_length-th sample
// produces one output beat (o_valid / i_stall) with ph_milli and
// average_q8; other samples only update the window.
// Registers are written through i_cfg_valid / o_cfg_ready (always ready),
// index 0 burst length, 1 slope, 2 intercept, 3 fallback; the user must
// write them only while idle, which the block does not enforce. Samples
// pass a two-entry queue; a plain sample waits there until the idle engine
// pops it into the ring. A burst-closing sample is stored the same way;
// the engine then reads every ring entry through the single-port window
// memory, trims, divides by reciprocal multiplication, saturates, scales
// and loads the output register. Throughput: one sample per cycle until a
// burst closes; the engine is then busy while the queue takes up to two more
// samples. Reset empties the ring (all entries read as zero), clears the
// burst count and loads the default calibration. A stalled result beat
// holds; the engine waits on it before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ph_trimmed_mean_filter_defines.svh"

module ph_trimmed_mean_filter #(
    parameter int WINDOW      = 40,
    parameter int SAMPLE_BITS = 12
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  [SAMPLE_BITS-1:0]               i_adc_sample,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic [phtm_pkg::MILLI_W-1:0]         o_ph_milli,
    output logic [phtm_pkg::AVG_W-1:0]           o_average_q8,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [phtm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [phtm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [phtm_pkg::BURST_W-1:0] r_burst_length;
    phtm_pkg::t_cal               r_cal;

    logic                         w_full;
    logic                         w_empty;
    logic                         w_push;
    logic                         w_pop;
    logic [SAMPLE_BITS:0]         w_fitem;
    logic [SAMPLE_BITS:0]         w_bitem;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_length        <= phtm_pkg::RST_BURST_LENGTH;
            r_cal.slope_q8        <= phtm_pkg::RST_SLOPE_Q8;
            r_cal.intercept_milli <= phtm_pkg::RST_INTERCEPT;
            r_cal.fallback_milli  <= phtm_pkg::RST_FALLBACK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (phtm_pkg::t_cfg_reg'(i_cfg_index))
                phtm_pkg::CFG_BURST_LENGTH:
                    r_burst_length <= i_cfg_data[phtm_pkg::BURST_W-1:0];
                phtm_pkg::CFG_SLOPE_Q8:
                    r_cal.slope_q8 <= i_cfg_data[phtm_pkg::SLOPE_W-1:0];
                phtm_pkg::CFG_INTERCEPT:
                    r_cal.intercept_milli <= i_cfg_data[phtm_pkg::MILLI_W-1:0];
                phtm_pkg::CFG_FALLBACK:
                    r_cal.fallback_milli <= i_cfg_data[phtm_pkg::MILLI_W-1:0];
                default: begin
                    r_burst_length <= r_burst_length;
                end
            endcase
        end
    end

    phtm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_adc_sample   (i_adc_sample),
        .i_burst_length (r_burst_length),
        .i_full         (w_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_item         (w_fitem)
    );

    phtm_queue #(
        .DATA_W (SAMPLE_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fitem),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_bitem)
    );

    phtm_back #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_item       (w_bitem),
        .o_pop        (w_pop),
        .i_cal        (r_cal),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ph_milli   (o_ph_milli),
        .o_average_q8 (o_average_q8)
    );

    `PHTM_ASSERT_SAME(a_pop_not_empty, w_pop, !w_empty)
    `PHTM_ASSERT_SAME(a_push_not_full, w_push, !w_full)
    `PHTM_ASSERT_NEXT(a_full_after_two, w_full && !w_pop, w_full || w_pop)

endmodule

`default_nettype wire
